>>> hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int POOL_PAGES   = 1024;
   localparam int ORDER_LEVELS = 11;
   localparam int TOP_ORDER    = ORDER_LEVELS - 1;
   localparam int ADDR_W       = $clog2(POOL_PAGES);
   localparam int ORD_W        = 4;
   localparam int CNT_W        = 11;
   localparam int CODE_W       = 6;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ORD_W-1:0]  ord_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CODE_W-1:0] code_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_BADFREE = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLR,
      OP_LOAD,
      OP_SCAN_RD,
      OP_NEXT_IDX,
      OP_NEXT_ORDER,
      OP_TAKE,
      OP_SPLIT,
      OP_GRANT,
      OP_FAIL_ALLOC,
      OP_FREE_RD,
      OP_FREE_BEGIN,
      OP_BUDDY_RD,
      OP_MERGE_A,
      OP_MERGE_B,
      OP_FREE_DONE,
      OP_FAIL_FREE
   } dp_op_type;

   typedef struct packed {
      logic clr_last;
      logic k_bad;
      logic cnt_zero;
      logic j_top;
      logic hit;
      logic idx_last;
      logic j_eq_k;
      logic head_ok;
      logic o_top;
      logic buddy_free;
      logic out_full;
   } dp_stat_type;

   function automatic code_type free_code(ord_type o);
      return {1'b0, o, 1'b1};
   endfunction

   function automatic code_type used_code(ord_type o);
      ord_type o1;
      o1 = o + ord_type'(1);
      return {1'b0, o1, 1'b0};
   endfunction

   function automatic cnt_type pages(ord_type o);
      return cnt_type'(1) << o;
   endfunction

endpackage

>>> hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clear, alloc search/split and free/merge.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_kind,
   output logic                 req_tready,
   input  bpa_pkg::dp_stat_type stat,
   output bpa_pkg::dp_op_type   op
);
   import bpa_pkg::*;

   typedef enum logic [14:0] {
      S_CLEAR     = 15'b000000000000001,
      S_IDLE      = 15'b000000000000010,
      S_ORDER     = 15'b000000000000100,
      S_SCAN_RD   = 15'b000000000001000,
      S_SCAN_CHK  = 15'b000000000010000,
      S_SPLIT     = 15'b000000000100000,
      S_GRANT     = 15'b000000001000000,
      S_FAIL1     = 15'b000000010000000,
      S_FREE_RD   = 15'b000000100000000,
      S_FREE_CHK  = 15'b000001000000000,
      S_BUDDY_RD  = 15'b000010000000000,
      S_BUDDY_CHK = 15'b000100000000000,
      S_MERGE_B   = 15'b001000000000000,
      S_FREE_DONE = 15'b010000000000000,
      S_FAIL2     = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            op = OP_CLR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op = OP_LOAD;
               if (req_kind) state_in = S_FREE_RD;
               else if (stat.k_bad) state_in = S_FAIL1;
               else state_in = S_ORDER;
            end
         end
         S_ORDER: begin
            if (!stat.cnt_zero) state_in = S_SCAN_RD;
            else if (stat.j_top) state_in = S_FAIL1;
            else op = OP_NEXT_ORDER;
         end
         S_SCAN_RD: begin
            op       = OP_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (stat.hit) begin
               op       = OP_TAKE;
               state_in = S_SPLIT;
            end else if (!stat.idx_last) begin
               op       = OP_NEXT_IDX;
               state_in = S_SCAN_RD;
            end else if (stat.j_top) begin
               state_in = S_FAIL1;
            end else begin
               op       = OP_NEXT_ORDER;
               state_in = S_ORDER;
            end
         end
         S_SPLIT: begin
            if (stat.j_eq_k) state_in = S_GRANT;
            else op = OP_SPLIT;
         end
         S_GRANT: begin
            if (!stat.out_full) begin
               op       = OP_GRANT;
               state_in = S_IDLE;
            end
         end
         S_FAIL1: begin
            if (!stat.out_full) begin
               op       = OP_FAIL_ALLOC;
               state_in = S_IDLE;
            end
         end
         S_FREE_RD: begin
            op       = OP_FREE_RD;
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (stat.head_ok) begin
               op       = OP_FREE_BEGIN;
               state_in = S_BUDDY_RD;
            end else begin
               state_in = S_FAIL2;
            end
         end
         S_BUDDY_RD: begin
            if (stat.o_top) begin
               state_in = S_FREE_DONE;
            end else begin
               op       = OP_BUDDY_RD;
               state_in = S_BUDDY_CHK;
            end
         end
         S_BUDDY_CHK: begin
            if (stat.buddy_free) begin
               op       = OP_MERGE_A;
               state_in = S_MERGE_B;
            end else begin
               state_in = S_FREE_DONE;
            end
         end
         S_MERGE_B: begin
            op       = OP_MERGE_B;
            state_in = S_BUDDY_RD;
         end
         S_FREE_DONE: begin
            if (!stat.out_full) begin
               op       = OP_FREE_DONE;
               state_in = S_IDLE;
            end
         end
         S_FAIL2: begin
            if (!stat.out_full) begin
               op       = OP_FAIL_FREE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   a_take_on_hit: assert property (@(posedge clock) disable iff (reset)
      (op == OP_TAKE) |-> stat.hit)
      else $error("take without matching head");
   a_no_load_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("input taken during clear");
   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_GRANT || op == OP_FREE_DONE) |-> !stat.out_full)
      else $error("result overwrote pending item");

endmodule

>>> hw/rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Head table, free counts, working registers and result register.
// ----------------------------------------------------------------------------
module bpa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bpa_pkg::dp_op_type            op,
   output bpa_pkg::dp_stat_type          stat,
   input  logic [bpa_pkg::CNT_W-1:0]     in_page_count,
   input  logic [bpa_pkg::ADDR_W-1:0]    in_block_start,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [1:0]                    out_status,
   output logic [bpa_pkg::ADDR_W-1:0]    out_start,
   output logic [bpa_pkg::ORD_W-1:0]     out_order,
   output logic [bpa_pkg::CNT_W-1:0]     out_free
);
   import bpa_pkg::*;

   code_type mem [POOL_PAGES];
   code_type rdata_ff;
   addr_type raddr, waddr;
   code_type wdata;
   logic     we;

   addr_type clr_ff, idx_ff, s_ff, start_ff;
   ord_type  j_ff, k_ff, o_ff, o0_ff;
   cnt_type  counts_ff [ORDER_LEVELS];
   cnt_type  total_ff;
   logic     valid_ff;
   status_type st_ff;
   addr_type res_start_ff;
   ord_type  res_order_ff;
   cnt_type  res_free_ff;

   cnt_type  cm1, idx_sum;
   ord_type  req_k, jd, dec_o;
   addr_type buddy;
   logic     res_load;

   always_comb begin
      cm1   = in_page_count - cnt_type'(1);
      req_k = '0;
      for (int b = 0; b < CNT_W; b++)
         if ((cm1 >> b) != '0) req_k = ord_type'(b + 1);
   end

   assign jd      = j_ff - ord_type'(1);
   assign dec_o   = ord_type'(rdata_ff[CODE_W-1:1] - 5'd1);
   assign idx_sum = cnt_type'(idx_ff) + pages(j_ff);
   assign buddy   = s_ff ^ addr_type'(pages(o_ff));
   assign res_load = op inside {OP_GRANT, OP_FAIL_ALLOC, OP_FAIL_FREE, OP_FREE_DONE};

   assign stat.clr_last   = (clr_ff == addr_type'(POOL_PAGES - 1));
   assign stat.k_bad      = (in_page_count == '0) ||
                            (in_page_count > cnt_type'(POOL_PAGES));
   assign stat.cnt_zero   = (counts_ff[j_ff] == '0);
   assign stat.j_top      = (j_ff == ord_type'(TOP_ORDER));
   assign stat.hit        = (rdata_ff == free_code(j_ff));
   assign stat.idx_last   = (idx_sum >= cnt_type'(POOL_PAGES));
   assign stat.j_eq_k     = (j_ff == k_ff);
   assign stat.head_ok    = !rdata_ff[0] && (rdata_ff != '0);
   assign stat.o_top      = (o_ff == ord_type'(TOP_ORDER));
   assign stat.buddy_free = (rdata_ff == free_code(o_ff));
   assign stat.out_full   = valid_ff && !out_ready;

   always_comb begin
      raddr = idx_ff;
      case (op)
         OP_FREE_RD:  raddr = start_ff;
         OP_BUDDY_RD: raddr = buddy;
         default:     raddr = idx_ff;
      endcase
   end

   always_comb begin
      we    = 1'b1;
      waddr = s_ff;
      wdata = '0;
      case (op)
         OP_CLR: begin
            waddr = clr_ff;
            wdata = (clr_ff == '0) ? free_code(ord_type'(TOP_ORDER)) : '0;
         end
         OP_SPLIT: begin
            waddr = addr_type'(cnt_type'(s_ff) + pages(jd));
            wdata = free_code(jd);
         end
         OP_GRANT:     wdata = used_code(k_ff);
         OP_MERGE_A:   waddr = buddy;
         OP_MERGE_B:   wdata = '0;
         OP_FREE_DONE: wdata = free_code(o_ff);
         default:      we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         total_ff <= cnt_type'(POOL_PAGES);
         valid_ff <= 1'b0;
         for (int i = 0; i < ORDER_LEVELS; i++)
            counts_ff[i] <= (i == TOP_ORDER) ? cnt_type'(1) : '0;
      end else begin
         if (res_load) valid_ff <= 1'b1;
         else if (valid_ff && out_ready) valid_ff <= 1'b0;
         case (op)
            OP_CLR: clr_ff <= clr_ff + addr_type'(1);
            OP_LOAD: begin
               j_ff     <= req_k;
               k_ff     <= req_k;
               idx_ff   <= '0;
               start_ff <= in_block_start;
               s_ff     <= in_block_start;
            end
            OP_NEXT_IDX: idx_ff <= idx_sum[ADDR_W-1:0];
            OP_NEXT_ORDER: begin
               j_ff   <= j_ff + ord_type'(1);
               idx_ff <= '0;
            end
            OP_TAKE: begin
               s_ff            <= idx_ff;
               counts_ff[j_ff] <= counts_ff[j_ff] - cnt_type'(1);
            end
            OP_SPLIT: begin
               j_ff          <= jd;
               counts_ff[jd] <= counts_ff[jd] + cnt_type'(1);
            end
            OP_GRANT: begin
               total_ff     <= total_ff - pages(k_ff);
               st_ff        <= ST_DONE;
               res_start_ff <= s_ff;
               res_order_ff <= k_ff;
               res_free_ff  <= total_ff - pages(k_ff);
            end
            OP_FAIL_ALLOC, OP_FAIL_FREE: begin
               st_ff        <= (op == OP_FAIL_ALLOC) ? ST_NOSPACE : ST_BADFREE;
               res_start_ff <= '0;
               res_order_ff <= '0;
               res_free_ff  <= total_ff;
            end
            OP_FREE_BEGIN: begin
               o_ff     <= dec_o;
               o0_ff    <= dec_o;
               total_ff <= total_ff + pages(dec_o);
            end
            OP_MERGE_A: counts_ff[o_ff] <= counts_ff[o_ff] - cnt_type'(1);
            OP_MERGE_B: begin
               s_ff <= s_ff & ~addr_type'(pages(o_ff));
               o_ff <= o_ff + ord_type'(1);
            end
            OP_FREE_DONE: begin
               counts_ff[o_ff] <= counts_ff[o_ff] + cnt_type'(1);
               st_ff           <= ST_DONE;
               res_start_ff    <= start_ff;
               res_order_ff    <= o0_ff;
               res_free_ff     <= total_ff;
            end
            default: ;
         endcase
      end
   end

   assign out_valid  = valid_ff;
   assign out_status = st_ff;
   assign out_start  = res_start_ff;
   assign out_order  = res_order_ff;
   assign out_free   = res_free_ff;

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= cnt_type'(POOL_PAGES))
      else $error("free page total out of range");
   a_grant_aligned: assert property (@(posedge clock) disable iff (reset)
      (op == OP_GRANT) |-> ((s_ff & addr_type'(pages(k_ff) - cnt_type'(1))) == '0))
      else $error("granted block misaligned");
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      (op == OP_GRANT) |-> (total_ff >= pages(k_ff)))
      else $error("grant exceeds free pages");

endmodule

>>> hw/rtl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Buddy allocator over a 1024-page pool, orders 0 to 10.
// ----------------------------------------------------------------------------
// One item at a time. After reset the head table is swept with req_tready
// low. After the accept cycle an alloc visits order levels, examines heads
// during the lowest-index search (one table read per entry, up to 1024
// entries at order 0) and then splits one level at a time; a free reads
// and checks its head, then merges one level at a time, and a rejected
// free ends after its head check. A result only waits when the previous
// one is still held. A finished item sits in the output register while
// the next item is accepted.
module buddy_page_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // page_count[10:0], block_start[20:11], zero
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // status[1:0], granted_start[11:2],
                                   // granted_order[15:12], free_pages[26:16], zero
);
   import bpa_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;
   logic [1:0]  out_status;
   addr_type    out_start;
   ord_type     out_order;
   cnt_type     out_free;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   bpa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .stat           (stat),
      .in_page_count  (req_tdata[10:0]),
      .in_block_start (req_tdata[20:11]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_status     (out_status),
      .out_start      (out_start),
      .out_order      (out_order),
      .out_free       (out_free)
   );

   assign rsp_tdata = {5'd0, out_free, out_order, out_start, out_status};

endmodule
